@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// edge of clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold on every active edge
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons must hold on the same edge as ante
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold on the edge after ante
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/pwt_pkg.sv @@
`timescale 1ns / 1ps
package pwt_pkg;

   // Width of the payload byte counter; longer lengths are rejected.
   localparam int LENGTH_BITS = 32;

   localparam int FIELD_BITS = 32;
   localparam int VALUE_BITS = 64;

   // Varint limits
   localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

   // Wire types
   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LEN     = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   localparam logic [LENGTH_BITS-1:0] SKIP_FIXED64 = LENGTH_BITS'(8);
   localparam logic [LENGTH_BITS-1:0] SKIP_FIXED32 = LENGTH_BITS'(4);

   // Token kinds
   localparam logic [2:0] TK_KEY   = 3'd0;
   localparam logic [2:0] TK_VALUE = 3'd1;
   localparam logic [2:0] TK_LEN   = 3'd2;
   localparam logic [2:0] TK_BYTE  = 3'd3;
   localparam logic [2:0] TK_ERROR = 3'd4;
   localparam logic [2:0] TK_END   = 3'd5;

   // Error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_WIRE  = 2'd1;
   localparam logic [1:0] ERR_LONG  = 2'd2;
   localparam logic [1:0] ERR_TRUNC = 2'd3;

   typedef enum logic [5:0] {
      PH_KEY     = 6'b000001,
      PH_VALUE   = 6'b000010,
      PH_LEN     = 6'b000100,
      PH_PAYLOAD = 6'b001000,
      PH_SKIP    = 6'b010000,
      PH_ERROR   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [2:0]            token_kind;
      logic [FIELD_BITS-1:0] field_number;
      logic [2:0]            wire_type;
      logic [VALUE_BITS-1:0] token_value;
      logic [1:0]            error_code;
      logic                  end_of_buffer;
   } token_type;

   // Packed widths of the result channel
   localparam int RSP_DATA_BITS  = FIELD_BITS + 3 + VALUE_BITS + 2;
   localparam int RSP_TDATA_BITS = ((RSP_DATA_BITS + 7) / 8) * 8;

endpackage

@@ design/protobuf_wire_tokenizer_core.sv @@
`timescale 1ns / 1ps
// Channel  | Ports   | Direction | Contents
// ---------+---------+-----------+---------------------------------------------
// request  | req_*   | in        | tdata = data_byte, tlast = last_byte
// result   | rsp_*   | out       | tdata = field/wire/value/error, tuser = kind,
//          |         |           | tlast = end_of_buffer
//
// One byte is taken per clock while req_tready is high; its token, if any, sits in the
// result register the next cycle, or in the skid entry if the result register is held.
// A single pass of decode logic lies between the request and the result register.
// A one-entry skid register behind the result register keeps req_tready free
// of rsp_tready; req_tready drops only while that skid entry is occupied.
// Reset (synchronous, active high) returns the decoder to the key phase and
// empties both result registers. The end of each buffer also returns the
// decoder to the key phase.
module protobuf_wire_tokenizer_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  logic                               req_tlast,  // last_byte
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] field_number, [34:32] wire_type, [98:35] token_value,
   // [100:99] error_code, [103:101] zero
   output logic [pwt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic [2:0]                         rsp_tuser,  // [2:0] token_kind
   output logic                               rsp_tlast   // end_of_buffer
);
   import pwt_pkg::*;

   `include "assert_macros.svh"

   // Decoder state
   phase_type                   phase_ff, phase_in;
   logic [VALUE_BITS-1:0]       acc_ff, acc_in;
   logic [3:0]                  cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0]       field_ff, field_in;
   logic [2:0]                  wire_ff, wire_in;
   logic [LENGTH_BITS-1:0]      remain_ff, remain_in;
   logic [1:0]                  sticky_ff, sticky_in;

   // Result and skid registers
   logic                        out_valid_ff, out_valid_in;
   token_type                   out_ff, out_in;
   logic                        skid_valid_ff, skid_valid_in;
   token_type                   skid_ff, skid_in;

   logic                        req_accept;
   logic                        rsp_take;
   logic                        emit;
   token_type                   token;

   // Varint byte placement
   logic [6:0]                  shift7;
   logic [VALUE_BITS-1:0]       acc_sum;
   logic [3:0]                  cnt_inc;
   logic [LENGTH_BITS-1:0]      remain_dec;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   // count * 7, at most 63 since the count never passes nine here
   assign shift7  = {cnt_ff, 3'b000} - {3'b000, cnt_ff};
   assign acc_sum = acc_ff | (VALUE_BITS'(req_tdata[6:0]) << shift7[5:0]);
   assign cnt_inc = cnt_ff + 4'd1;
   assign remain_dec = (remain_ff != '0) ? remain_ff - LENGTH_BITS'(1) : remain_ff;

   // Decode one byte
   always_comb begin
      logic                  err_now;
      logic [1:0]            err_code;
      logic [2:0]            kind;
      logic [VALUE_BITS-1:0] value;

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      field_in  = field_ff;
      wire_in   = wire_ff;
      remain_in = remain_ff;
      sticky_in = sticky_ff;
      emit      = 1'b0;
      err_now   = 1'b0;
      err_code  = ERR_NONE;
      kind      = TK_KEY;
      value     = '0;

      case (phase_ff)
         PH_KEY, PH_VALUE, PH_LEN: begin
            if (req_tdata[7] && cnt_inc >= VARINT_MAX_BYTES) begin
               // Overlong varint
               acc_in    = acc_sum;
               cnt_in    = cnt_inc;
               sticky_in = ERR_LONG;
               phase_in  = PH_ERROR;
               emit      = 1'b1;
               err_now   = 1'b1;
               kind      = TK_ERROR;
               err_code  = ERR_LONG;
            end else if (req_tdata[7]) begin
               acc_in = acc_sum;
               cnt_in = cnt_inc;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               emit   = 1'b1;
               case (phase_ff)
                  PH_KEY: begin
                     field_in = acc_sum[FIELD_BITS+2:3];
                     wire_in  = acc_sum[2:0];
                     kind     = TK_KEY;
                     if (acc_sum[2:0] == WIRE_VARINT) begin
                        phase_in = PH_VALUE;
                     end else if (acc_sum[2:0] == WIRE_LEN) begin
                        phase_in = PH_LEN;
                     end else if (acc_sum[2:0] inside {WIRE_FIXED64, WIRE_FIXED32}) begin
                        phase_in  = PH_SKIP;
                        remain_in = (acc_sum[2:0] == WIRE_FIXED64) ? SKIP_FIXED64
                                                                   : SKIP_FIXED32;
                     end else begin
                        sticky_in = ERR_WIRE;
                        phase_in  = PH_ERROR;
                        err_now   = 1'b1;
                        kind      = TK_ERROR;
                        err_code  = ERR_WIRE;
                     end
                  end
                  PH_VALUE: begin
                     phase_in = PH_KEY;
                     kind     = TK_VALUE;
                     value    = acc_sum;
                  end
                  default: begin
                     // Length varint; reject anything the byte counter cannot hold
                     if (acc_sum[VALUE_BITS-1:LENGTH_BITS] != '0) begin
                        sticky_in = ERR_TRUNC;
                        phase_in  = PH_ERROR;
                        err_now   = 1'b1;
                        kind      = TK_ERROR;
                        err_code  = ERR_TRUNC;
                     end else begin
                        remain_in = acc_sum[LENGTH_BITS-1:0];
                        phase_in  = (acc_sum == '0) ? PH_KEY : PH_PAYLOAD;
                        kind      = TK_LEN;
                        value     = acc_sum;
                     end
                  end
               endcase
            end
         end
         PH_PAYLOAD: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_KEY;
            end
            emit  = 1'b1;
            kind  = TK_BYTE;
            value = VALUE_BITS'(req_tdata);
         end
         PH_SKIP: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               phase_in = PH_KEY;
            end
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // Close the buffer: report truncation or the sticky error, or mark a clean end, then clear
      if (req_tlast && !err_now) begin
         if (phase_in == PH_ERROR) begin
            emit     = 1'b1;
            kind     = TK_END;
            value    = '0;
            err_code = sticky_in;
         end else if (phase_in != PH_KEY || cnt_in != '0) begin
            emit     = 1'b1;
            kind     = TK_ERROR;
            value    = '0;
            err_code = ERR_TRUNC;
         end else if (!emit) begin
            emit     = 1'b1;
            kind     = TK_END;
            value    = '0;
            err_code = ERR_NONE;
         end
      end

      token.token_kind    = kind;
      token.field_number  = field_in;
      token.wire_type     = wire_in;
      token.token_value   = value;
      token.error_code    = err_code;
      token.end_of_buffer = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_KEY;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         field_ff  <= '0;
         wire_ff   <= '0;
         remain_ff <= '0;
         sticky_ff <= ERR_NONE;
      end else if (req_accept) begin
         if (req_tlast) begin
            // Drop all decoder state at the end of a buffer
            phase_ff  <= PH_KEY;
            acc_ff    <= '0;
            cnt_ff    <= '0;
            field_ff  <= '0;
            wire_ff   <= '0;
            remain_ff <= '0;
            sticky_ff <= ERR_NONE;
         end else begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            cnt_ff    <= cnt_in;
            field_ff  <= field_in;
            wire_ff   <= wire_in;
            remain_ff <= remain_in;
            sticky_ff <= sticky_in;
         end
      end
   end

   // Result register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff && (rsp_take || !out_valid_ff)) begin
         // Advance the parked token
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else if (req_accept && emit) begin
         if (!out_valid_ff || rsp_take) begin
            out_valid_in = 1'b1;
            out_in       = token;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = token;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.token_kind;
   assign rsp_tlast  = out_ff.end_of_buffer;
   assign rsp_tdata  = RSP_TDATA_BITS'({out_ff.error_code, out_ff.token_value,
                                        out_ff.wire_type, out_ff.field_number});

   // The count parks at ten after an overlong varint until the buffer ends
   `ASSERT_IMPLIES(a_skid_behind_out, skid_valid_ff, out_valid_ff,
                   "skid entry ahead of result")
   `ASSERT_ALWAYS(a_sticky_phase, (sticky_ff != ERR_NONE) == (phase_ff == PH_ERROR),
                  "sticky mismatch")
   `ASSERT_IMPLIES(a_varint_count, phase_ff != PH_ERROR, cnt_ff < VARINT_MAX_BYTES,
                   "varint count past limit")
   `ASSERT_IMPLIES(a_remain_live, phase_ff == PH_PAYLOAD || phase_ff == PH_SKIP,
                   remain_ff != '0, "no bytes owed")
   `ASSERT_NEXT(a_buffer_end_clears, req_accept && req_tlast,
                phase_ff == PH_KEY && cnt_ff == '0 && sticky_ff == ERR_NONE,
                "state kept after buffer end")

endmodule

@@ tb/pwt_token_checker.sv @@
`timescale 1ns / 1ps
module pwt_token_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [pwt_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic [2:0]                         rsp_tuser,
   input  logic                               rsp_tlast,
   output int                                 mismatch_count,
   output int                                 pending_tokens
);
   import pwt_pkg::*;

   // decoder state tracked on the request side
   phase_type              dec_phase;
   logic [63:0]            varint_acc;
   logic [3:0]             varint_len;
   logic [31:0]            key_field;
   logic [2:0]             key_wire;
   logic [LENGTH_BITS-1:0] owed_bytes;
   logic [1:0]             stuck_err;

   token_type expected_tokens[$];
   int        mismatches = 0;
   int        tokens_checked = 0;

   function automatic void clear_decoder();
      dec_phase  = PH_KEY;
      varint_acc = '0;
      varint_len = '0;
      key_field  = '0;
      key_wire   = '0;
      owed_bytes = '0;
      stuck_err  = ERR_NONE;
   endfunction

   function automatic token_type fill_token(input logic [2:0] kind, input logic [63:0] value,
                                            input logic [1:0] code);
      token_type tok;
      tok.token_kind    = kind;
      tok.field_number  = key_field;
      tok.wire_type     = key_wire;
      tok.token_value   = value;
      tok.error_code    = code;
      tok.end_of_buffer = 1'b0;
      return tok;
   endfunction

   function automatic token_type raise_fault(input logic [1:0] code);
      stuck_err = code;
      dec_phase = PH_ERROR;
      return fill_token(TK_ERROR, '0, code);
   endfunction

   // Advance the decoder by one byte; return 1 when the byte yields a token.
   function automatic bit predict_token(input logic [7:0] b, input logic last,
                                        output token_type tok);
      logic [63:0] v;
      int          status;
      bit          made;
      bit          err_now;
      made    = 1'b0;
      err_now = 1'b0;
      tok     = '0;
      case (dec_phase)
         PH_KEY, PH_VALUE, PH_LEN: begin
            // groups past bit 63 are dropped
            if (varint_len <= 4'd9)
               varint_acc |= 64'(b[6:0]) << (7 * varint_len);
            varint_len = varint_len + 4'd1;
            if (!b[7])
               status = 1;
            else if (varint_len >= VARINT_MAX_BYTES)
               status = -1;
            else
               status = 0;
            if (status < 0) begin
               tok     = raise_fault(ERR_LONG);
               made    = 1'b1;
               err_now = 1'b1;
            end else if (status > 0) begin
               v          = varint_acc;
               varint_acc = '0;
               varint_len = '0;
               if (dec_phase == PH_KEY) begin
                  key_field = v[34:3];
                  key_wire  = v[2:0];
                  if (key_wire == WIRE_VARINT) begin
                     dec_phase = PH_VALUE;
                  end else if (key_wire == WIRE_LEN) begin
                     dec_phase = PH_LEN;
                  end else if (key_wire == WIRE_FIXED64) begin
                     dec_phase  = PH_SKIP;
                     owed_bytes = SKIP_FIXED64;
                  end else if (key_wire == WIRE_FIXED32) begin
                     dec_phase  = PH_SKIP;
                     owed_bytes = SKIP_FIXED32;
                  end else begin
                     tok     = raise_fault(ERR_WIRE);
                     err_now = 1'b1;
                  end
                  if (!err_now)
                     tok = fill_token(TK_KEY, '0, ERR_NONE);
                  made = 1'b1;
               end else if (dec_phase == PH_VALUE) begin
                  dec_phase = PH_KEY;
                  tok       = fill_token(TK_VALUE, v, ERR_NONE);
                  made      = 1'b1;
               end else begin
                  // a length that overflows the counter can never be satisfied
                  if ((v >> LENGTH_BITS) != 0) begin
                     tok     = raise_fault(ERR_TRUNC);
                     err_now = 1'b1;
                  end else begin
                     owed_bytes = v[LENGTH_BITS-1:0];
                     dec_phase  = (v == 0) ? PH_KEY : PH_PAYLOAD;
                     tok        = fill_token(TK_LEN, v, ERR_NONE);
                  end
                  made = 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            if (owed_bytes != 0)
               owed_bytes = owed_bytes - 1'b1;
            if (owed_bytes == 0)
               dec_phase = PH_KEY;
            tok  = fill_token(TK_BYTE, 64'(b), ERR_NONE);
            made = 1'b1;
         end
         PH_SKIP: begin
            if (owed_bytes != 0)
               owed_bytes = owed_bytes - 1'b1;
            if (owed_bytes == 0)
               dec_phase = PH_KEY;
         end
         default: begin
            dec_phase = PH_ERROR;
         end
      endcase

      if (last) begin
         if (!err_now) begin
            if (dec_phase == PH_ERROR)
               tok = fill_token(TK_END, '0, stuck_err);
            else if (dec_phase != PH_KEY || varint_len != 0)
               tok = fill_token(TK_ERROR, '0, ERR_TRUNC);
            else if (!made)
               tok = fill_token(TK_END, '0, ERR_NONE);
         end
         made              = 1'b1;
         tok.end_of_buffer = 1'b1;
         clear_decoder();
      end
      return made;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < 40)
         $display("%0t: token %0d %s: got %0h, want %0h", $time, tokens_checked, what, got,
                  want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      token_type want;
      token_type tok;
      if (reset) begin
         clear_decoder();
         expected_tokens.delete();
      end else begin
         // check results before predicting: a request never answers in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("token with none expected, kind", 64'(rsp_tuser), '0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_tuser !== want.token_kind)
                  report_mismatch("token_kind", 64'(rsp_tuser), 64'(want.token_kind));
               if (rsp_tdata[31:0] !== want.field_number)
                  report_mismatch("field_number", 64'(rsp_tdata[31:0]), 64'(want.field_number));
               if (rsp_tdata[34:32] !== want.wire_type)
                  report_mismatch("wire_type", 64'(rsp_tdata[34:32]), 64'(want.wire_type));
               if (rsp_tdata[98:35] !== want.token_value)
                  report_mismatch("token_value", rsp_tdata[98:35], want.token_value);
               if (rsp_tdata[100:99] !== want.error_code)
                  report_mismatch("error_code", 64'(rsp_tdata[100:99]), 64'(want.error_code));
               if (rsp_tdata[RSP_TDATA_BITS-1:RSP_DATA_BITS] !== '0)
                  report_mismatch("tdata padding",
                                  64'(rsp_tdata[RSP_TDATA_BITS-1:RSP_DATA_BITS]), '0);
               if (rsp_tlast !== want.end_of_buffer)
                  report_mismatch("end_of_buffer", 64'(rsp_tlast), 64'(want.end_of_buffer));
            end
            tokens_checked++;
         end
         if (req_tvalid && req_tready) begin
            if (predict_token(req_tdata, req_tlast, tok))
               expected_tokens.push_back(tok);
         end
      end
      mismatch_count <= mismatches;
      pending_tokens <= expected_tokens.size();
   end

endmodule

@@ tb/protobuf_wire_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps
module protobuf_wire_tokenizer_core_tb;
   import pwt_pkg::*;

   localparam int BYTE_BUDGET    = 1800;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLDOFF_CYCLES = 64;

   // wire types the block must reject
   localparam logic [2:0] WIRE_GROUP_START = 3'd3;
   localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
   localparam logic [2:0] WIRE_RESERVED6   = 3'd6;
   localparam logic [2:0] WIRE_RESERVED7   = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = 8'h00;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [2:0]                rsp_tuser;
   logic                      rsp_tlast;

   int mismatch_count;
   int pending_tokens;

   // stimulus controls; the result side reads these and counts its hold-offs in holdoffs_done
   bit          req_gaps_on = 1'b1;
   bit          rsp_stall_on = 1'b1;
   int          holdoffs_asked = 0;
   int          holdoffs_done = 0;
   int          bytes_sent = 0;
   int unsigned cycle_count = 0;

   // bytes of the buffer being built, sent in order with tlast on the final one
   logic [7:0]  frame_bytes[$];

   always #6 clock = ~clock;

   protobuf_wire_tokenizer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   pwt_token_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_tokens (pending_tokens)
   );

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Buffer builders
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] make_key(input logic [63:0] fnum, input logic [2:0] wtype);
      return (fnum << 3) | 64'(wtype);
   endfunction

   // Mostly canonical; now and then pad with redundant continuation bytes.
   function automatic int rand_pad();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   // Append value as a varint of its minimal length plus pad bytes, ten at most.
   function automatic void put_varint(input logic [63:0] value, input int pad);
      int          groups;
      int          total;
      int          i;
      logic [63:0] rest;
      logic [7:0]  b;
      groups = 1;
      rest   = value >> 7;
      while (rest != 0) begin
         groups++;
         rest = rest >> 7;
      end
      total = groups + pad;
      if (total > 10)
         total = 10;
      for (i = 0; i < total; i++) begin
         b    = {1'b0, 7'(value >> (7 * i))};
         b[7] = (i < total - 1);
         frame_bytes.push_back(b);
      end
   endfunction

   // Append an n-byte varint of random content; ten bytes reach past bit 63.
   function automatic void put_raw_varint(input int n);
      int         i;
      logic [7:0] b;
      for (i = 0; i < n; i++) begin
         b    = 8'($urandom);
         b[7] = (i < n - 1);
         frame_bytes.push_back(b);
      end
   endfunction

   // Ten bytes that all ask for one more.
   function automatic void put_overlong();
      repeat (10) frame_bytes.push_back(8'($urandom) | 8'h80);
   endfunction

   function automatic logic [63:0] pick_field_number();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 64'($urandom_range(0, 15));
         6, 7:             return 64'($urandom_range(16, 2047));
         8:                return 64'($urandom);
         default:          return {$urandom, $urandom} >> 3;
      endcase
   endfunction

   // Append one well-formed field with random content.
   function automatic void put_field();
      logic [63:0] fnum;
      int          pick;
      int          len;
      fnum = pick_field_number();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         put_varint(make_key(fnum, WIRE_VARINT), rand_pad());
         put_raw_varint(($urandom_range(0, 3) == 0) ? $urandom_range(1, 10)
                                                    : $urandom_range(1, 3));
      end else if (pick < 75) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
         put_varint(make_key(fnum, WIRE_LEN), rand_pad());
         put_varint(64'(len), rand_pad());
         repeat (len) frame_bytes.push_back(8'($urandom));
      end else if (pick < 88) begin
         put_varint(make_key(fnum, WIRE_FIXED64), rand_pad());
         repeat (8) frame_bytes.push_back(8'($urandom));
      end else begin
         put_varint(make_key(fnum, WIRE_FIXED32), rand_pad());
         repeat (4) frame_bytes.push_back(8'($urandom));
      end
   endfunction

   // Append one broken item: bad wire type, overlong varint or oversized length.
   function automatic void put_fault();
      logic [2:0]  bad_wire;
      logic [63:0] huge;
      case ($urandom_range(0, 3))
         0:       bad_wire = WIRE_GROUP_START;
         1:       bad_wire = WIRE_GROUP_END;
         2:       bad_wire = WIRE_RESERVED6;
         default: bad_wire = WIRE_RESERVED7;
      endcase
      case ($urandom_range(0, 2))
         0:       huge = 64'h0000_0001_0000_0000;
         1:       huge = '1;
         default: huge = {$urandom, $urandom} | 64'h0000_0001_0000_0000;
      endcase
      case ($urandom_range(0, 4))
         0: put_varint(make_key(pick_field_number(), bad_wire), rand_pad());
         1: put_overlong();
         2: begin
            put_varint(make_key(pick_field_number(), WIRE_VARINT), 0);
            put_overlong();
         end
         3: begin
            put_varint(make_key(pick_field_number(), WIRE_LEN), 0);
            put_overlong();
         end
         default: begin
            put_varint(make_key(pick_field_number(), WIRE_LEN), 0);
            put_varint(huge, 0);
         end
      endcase
   endfunction

   // Build one buffer: mostly clean fields, some with a fault, some cut short.
   function automatic void build_frame();
      int fields;
      int fault_at;
      int cut;
      int k;
      bit broken;
      bit truncate;
      bit done;
      frame_bytes.delete();
      fields   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
      broken   = ($urandom_range(0, 99) < 12);
      truncate = !broken && ($urandom_range(0, 99) < 10);
      fault_at = $urandom_range(0, fields - 1);
      done     = 1'b0;
      for (k = 0; k < fields && !done; k++) begin
         if (broken && k == fault_at) begin
            // trailing bytes after a fault are ignored up to the end marker
            put_fault();
            repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom));
            done = 1'b1;
         end else begin
            put_field();
         end
      end
      if (truncate && frame_bytes.size() > 1) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut)
            void'(frame_bytes.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Offer one request and hold it until the block takes it.
   task automatic send_request(input logic [7:0] data, input logic last);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      int i;
      for (i = 0; i < frame_bytes.size(); i++)
         send_request(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stall bursts, plus long hold-offs on request so the
   // skid entry fills and req_tready drops while requests keep coming.
   // ---------------------------------------------------------------------------
   initial begin : result_side
      int stall;
      forever begin
         @(posedge clock);
         if (holdoffs_done < holdoffs_asked) begin
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoffs_done++;
            rsp_tready <= 1'b1;
         end else if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(1, 5);
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int frames;
      bit paused;
      bit quiet_tail;
      frames     = 0;
      paused     = 1'b0;
      quiet_tail = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Field 0 key, then an all-ones value whose tenth byte has bits above 63.
      frame_bytes.delete();
      put_varint(make_key(64'd0, WIRE_VARINT), 0);
      repeat (9) frame_bytes.push_back(8'hff);
      frame_bytes.push_back(8'h7f);
      send_frame();

      // Bad wire type on the buffer's only byte.
      frame_bytes.delete();
      put_varint(make_key(64'd1, WIRE_RESERVED7), 0);
      send_frame();

      // Fixed32 skip that ends the buffer: an end-only token.
      frame_bytes.delete();
      put_varint(make_key(64'd1, WIRE_FIXED32), 0);
      repeat (4) frame_bytes.push_back(8'($urandom));
      send_frame();

      // Buffer ends inside a payload.
      frame_bytes.delete();
      put_varint(make_key(64'd3, WIRE_LEN), 0);
      put_varint(64'd3, 0);
      frame_bytes.push_back(8'hff);
      send_frame();

      // Overlong key varint ending the buffer.
      frame_bytes.delete();
      repeat (10) frame_bytes.push_back(8'h80);
      send_frame();

      while (bytes_sent < BYTE_BUDGET) begin
         // vary idling in stretches; drop it for the last part of the run
         if (!quiet_tail && bytes_sent >= BYTE_BUDGET * 9 / 10) begin
            quiet_tail   = 1'b1;
            req_gaps_on  = 1'b0;
            rsp_stall_on <= 1'b0;
         end else if (!quiet_tail && frames % 10 == 0) begin
            req_gaps_on  = ($urandom_range(0, 2) != 0);
            rsp_stall_on <= ($urandom_range(0, 2) != 0);
         end

         // drain every outstanding token once mid-run
         if (!paused && bytes_sent >= 300) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_tokens != 0)
               @(posedge clock);
         end

         // hold off the result side twice while requests keep flowing
         if ((holdoffs_asked == 0 && bytes_sent >= 500) ||
             (holdoffs_asked == 1 && bytes_sent >= 1100))
            holdoffs_asked <= holdoffs_asked + 1;

         build_frame();
         send_frame();
         frames++;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_tokens != 0)
         @(posedge clock);
      // allow for a stray late token from the result and skid registers
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/pwt_pkg.sv
design/protobuf_wire_tokenizer_core.sv
tb/pwt_token_checker.sv
tb/protobuf_wire_tokenizer_core_tb.sv
